FILE: hdl/virtio_mmio_register_block_defines.svh
// Assertion macros shared by the virtio MMIO register block RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
// No other file or package is needed.
`ifndef VIRTIO_MMIO_REGISTER_BLOCK_DEFINES_SVH
`define VIRTIO_MMIO_REGISTER_BLOCK_DEFINES_SVH

`ifndef SYNTHESIS
`define VMMIO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("virtio mmio register block: same-cycle check failed");
`define VMMIO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("virtio mmio register block: next-cycle check failed");
`else
`define VMMIO_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VMMIO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/vmmio_pkg.sv
// Types and constants of the virtio MMIO register block.
// Holds register offsets, access kinds and the result item layout; depends on nothing.
package vmmio_pkg;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RAISE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_DEVICE_KIND      = 2'd0,
        CFG_VENDOR_CODE      = 2'd1,
        CFG_OFFERED_FEATURES = 2'd2,
        CFG_QUEUE_COUNT      = 2'd3
    } t_cfg_index;

    localparam logic [11:0] OFF_MAGIC          = 12'h000;
    localparam logic [11:0] OFF_VERSION        = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID      = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID      = 12'h00C;
    localparam logic [11:0] OFF_DEV_FEATURES   = 12'h010;
    localparam logic [11:0] OFF_DEV_FEAT_SEL   = 12'h014;
    localparam logic [11:0] OFF_DRV_FEATURES   = 12'h020;
    localparam logic [11:0] OFF_DRV_FEAT_SEL   = 12'h024;
    localparam logic [11:0] OFF_QUEUE_SEL      = 12'h030;
    localparam logic [11:0] OFF_QUEUE_NUM_MAX  = 12'h034;
    localparam logic [11:0] OFF_QUEUE_NUM      = 12'h038;
    localparam logic [11:0] OFF_QUEUE_READY    = 12'h044;
    localparam logic [11:0] OFF_QUEUE_NOTIFY   = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS     = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK        = 12'h064;
    localparam logic [11:0] OFF_STATUS         = 12'h070;
    localparam logic [11:0] OFF_DESC_LOW       = 12'h080;
    localparam logic [11:0] OFF_DESC_HIGH      = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LOW      = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HIGH     = 12'h094;
    localparam logic [11:0] OFF_USED_LOW       = 12'h0A0;
    localparam logic [11:0] OFF_USED_HIGH      = 12'h0A4;

    localparam logic [31:0] MAGIC_VALUE    = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE  = 32'd2;
    localparam logic [31:0] DEFAULT_VENDOR = 32'h554D_4551;
    localparam int          STATUS_DRIVER_OK_BIT = 2;

    typedef struct packed {
        logic        unhandled_access;
        logic        irq_pending;
        logic        reset_event;
        logic        driver_ok_event;
        logic [2:0]  notify_queue;
        logic        notify_valid;
        logic [31:0] read_data;
    } t_result;

endpackage

FILE: hdl/virtio_mmio_register_block.sv
// Register file of a version-2 virtio MMIO transport, in a single module.
// Depends on vmmio_pkg and on virtio_mmio_register_block_defines.svh for assertions.
//
// Usage:
// The slave stream carries one bus access per item: tuser selects a read, a write
// or an interrupt raise, and tdata holds the register offset and the write data.
// The master stream returns exactly one result item per accepted item: read data,
// the queue notify, DRIVER_OK and device reset events, the interrupt line state
// and an unhandled-access flag. A separate config channel sets the device id,
// vendor id, offered features and queue count; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// The result is registered: an item accepted at one edge has its result on the
// master side after that edge. Throughput is one item per cycle while results are
// taken, set by the single decode and update pass that feeds the result register.
// When the receiver stalls, the result register holds and o_s_tready drops, so
// the slave side waits; it rises again in the cycle the result is taken.
// A synchronous reset clears the queue state, the config and all other registers but the result data,
// with queue count one; the block accepts items in the first cycle after reset.
`include "virtio_mmio_register_block_defines.svh"

module virtio_mmio_register_block #(
    parameter int MAX_QUEUES    = 8,
    parameter int QUEUE_NUM_MAX = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream of access items.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,   // mode
    input  logic [47:0] i_s_tdata,   // reg_offset [11:0], write_data [43:12], zero fill
    // Master stream of result items.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // read_data, notify_valid, notify_queue,
                                     // driver_ok_event, reset_event, irq_pending,
                                     // unhandled_access
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;

    logic [7:0]  r_device_kind;
    logic [31:0] r_vendor_code;
    logic [63:0] r_offered_features;
    logic [3:0]  r_queue_count;

    logic        r_dev_feat_select, n_dev_feat_select;
    logic        r_drv_feat_select, n_drv_feat_select;
    logic [63:0] r_accepted_features, n_accepted_features;
    logic [31:0] r_selected_queue, n_selected_queue;
    logic [31:0] r_device_status, n_device_status;
    logic [31:0] r_interrupt_bits, n_interrupt_bits;

    logic [15:0] r_queue_size [MAX_QUEUES];
    logic [15:0] n_queue_size [MAX_QUEUES];
    logic        r_queue_ready [MAX_QUEUES];
    logic        n_queue_ready [MAX_QUEUES];
    logic [63:0] r_desc_addr [MAX_QUEUES];
    logic [63:0] n_desc_addr [MAX_QUEUES];
    logic [63:0] r_avail_addr [MAX_QUEUES];
    logic [63:0] n_avail_addr [MAX_QUEUES];
    logic [63:0] r_used_addr [MAX_QUEUES];
    logic [63:0] n_used_addr [MAX_QUEUES];

    logic                 r_out_valid;
    vmmio_pkg::t_result   r_out;
    vmmio_pkg::t_result   result;

    logic          s_accept;
    logic [11:0]   in_offset;
    logic [31:0]   in_data;
    logic [31:0]   live_queues;
    logic          sel_ok;
    logic [QW-1:0] qidx;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign in_offset   = i_s_tdata[11:0];
    assign in_data     = i_s_tdata[43:12];
    assign o_cfg_ready = 1'b1;

    assign live_queues = ({28'd0, r_queue_count} < 32'(MAX_QUEUES)) ?
                         {28'd0, r_queue_count} : 32'(MAX_QUEUES);
    assign sel_ok      = r_selected_queue < live_queues;
    assign qidx        = r_selected_queue[QW-1:0];

    always_comb begin
        n_dev_feat_select   = r_dev_feat_select;
        n_drv_feat_select   = r_drv_feat_select;
        n_accepted_features = r_accepted_features;
        n_selected_queue    = r_selected_queue;
        n_device_status     = r_device_status;
        n_interrupt_bits    = r_interrupt_bits;
        n_queue_size        = r_queue_size;
        n_queue_ready       = r_queue_ready;
        n_desc_addr         = r_desc_addr;
        n_avail_addr        = r_avail_addr;
        n_used_addr         = r_used_addr;
        result              = '0;

        if (s_accept) begin
            case (vmmio_pkg::t_mode'(i_s_tuser))
                vmmio_pkg::MODE_READ: begin
                    case (in_offset)
                        vmmio_pkg::OFF_MAGIC:         result.read_data = vmmio_pkg::MAGIC_VALUE;
                        vmmio_pkg::OFF_VERSION:       result.read_data = vmmio_pkg::VERSION_VALUE;
                        vmmio_pkg::OFF_DEVICE_ID:     result.read_data = {24'd0, r_device_kind};
                        vmmio_pkg::OFF_VENDOR_ID: begin
                            result.read_data = (r_vendor_code != 32'd0) ?
                                               r_vendor_code : vmmio_pkg::DEFAULT_VENDOR;
                        end
                        vmmio_pkg::OFF_DEV_FEATURES: begin
                            result.read_data = r_dev_feat_select ?
                                               r_offered_features[63:32] :
                                               r_offered_features[31:0];
                        end
                        vmmio_pkg::OFF_QUEUE_NUM_MAX: result.read_data = 32'(QUEUE_NUM_MAX);
                        vmmio_pkg::OFF_QUEUE_READY: begin
                            result.read_data = {31'd0, sel_ok && r_queue_ready[qidx]};
                        end
                        vmmio_pkg::OFF_IRQ_STATUS:    result.read_data = r_interrupt_bits;
                        vmmio_pkg::OFF_STATUS:        result.read_data = r_device_status;
                        default:                      result.unhandled_access = 1'b1;
                    endcase
                end
                vmmio_pkg::MODE_WRITE: begin
                    case (in_offset)
                        vmmio_pkg::OFF_DEV_FEAT_SEL: n_dev_feat_select = in_data[0];
                        vmmio_pkg::OFF_DRV_FEATURES: begin
                            if (r_drv_feat_select) begin
                                n_accepted_features[63:32] = in_data;
                            end else begin
                                n_accepted_features[31:0] = in_data;
                            end
                        end
                        vmmio_pkg::OFF_DRV_FEAT_SEL: n_drv_feat_select = in_data[0];
                        vmmio_pkg::OFF_QUEUE_SEL:    n_selected_queue = in_data;
                        vmmio_pkg::OFF_QUEUE_NUM: begin
                            if (sel_ok) n_queue_size[qidx] = in_data[15:0];
                        end
                        vmmio_pkg::OFF_QUEUE_READY: begin
                            if (sel_ok) n_queue_ready[qidx] = in_data[0];
                        end
                        vmmio_pkg::OFF_QUEUE_NOTIFY: begin
                            if (in_data < live_queues) begin
                                result.notify_valid = 1'b1;
                                result.notify_queue = in_data[2:0];
                            end
                        end
                        vmmio_pkg::OFF_IRQ_ACK: n_interrupt_bits = r_interrupt_bits & ~in_data;
                        vmmio_pkg::OFF_STATUS: begin
                            n_device_status = in_data;
                            result.driver_ok_event =
                                in_data[vmmio_pkg::STATUS_DRIVER_OK_BIT] &&
                                !r_device_status[vmmio_pkg::STATUS_DRIVER_OK_BIT];
                            if (in_data == 32'd0 && r_device_status != 32'd0) begin
                                result.reset_event  = 1'b1;
                                n_accepted_features = '0;
                                n_dev_feat_select   = 1'b0;
                                n_drv_feat_select   = 1'b0;
                                n_interrupt_bits    = '0;
                                for (int i = 0; i < MAX_QUEUES; i++) begin
                                    n_queue_size[i]  = '0;
                                    n_queue_ready[i] = 1'b0;
                                    n_desc_addr[i]   = '0;
                                    n_avail_addr[i]  = '0;
                                    n_used_addr[i]   = '0;
                                end
                            end
                        end
                        vmmio_pkg::OFF_DESC_LOW: begin
                            if (sel_ok) n_desc_addr[qidx][31:0] = in_data;
                        end
                        vmmio_pkg::OFF_DESC_HIGH: begin
                            if (sel_ok) n_desc_addr[qidx][63:32] = in_data;
                        end
                        vmmio_pkg::OFF_AVAIL_LOW: begin
                            if (sel_ok) n_avail_addr[qidx][31:0] = in_data;
                        end
                        vmmio_pkg::OFF_AVAIL_HIGH: begin
                            if (sel_ok) n_avail_addr[qidx][63:32] = in_data;
                        end
                        vmmio_pkg::OFF_USED_LOW: begin
                            if (sel_ok) n_used_addr[qidx][31:0] = in_data;
                        end
                        vmmio_pkg::OFF_USED_HIGH: begin
                            if (sel_ok) n_used_addr[qidx][63:32] = in_data;
                        end
                        default: result.unhandled_access = 1'b1;
                    endcase
                end
                vmmio_pkg::MODE_RAISE: n_interrupt_bits = r_interrupt_bits | in_data;
                default: ;
            endcase
        end
        result.irq_pending = (n_interrupt_bits != 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_kind       <= '0;
            r_vendor_code       <= '0;
            r_offered_features  <= '0;
            r_queue_count       <= 4'd1;
        end else if (i_cfg_valid) begin
            case (vmmio_pkg::t_cfg_index'(i_cfg_index))
                vmmio_pkg::CFG_DEVICE_KIND:      r_device_kind      <= i_cfg_data[7:0];
                vmmio_pkg::CFG_VENDOR_CODE:      r_vendor_code      <= i_cfg_data[31:0];
                vmmio_pkg::CFG_OFFERED_FEATURES: r_offered_features <= i_cfg_data;
                vmmio_pkg::CFG_QUEUE_COUNT:      r_queue_count      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_feat_select   <= 1'b0;
            r_drv_feat_select   <= 1'b0;
            r_accepted_features <= '0;
            r_selected_queue    <= '0;
            r_device_status     <= '0;
            r_interrupt_bits    <= '0;
            for (int i = 0; i < MAX_QUEUES; i++) begin
                r_queue_size[i]  <= '0;
                r_queue_ready[i] <= 1'b0;
                r_desc_addr[i]   <= '0;
                r_avail_addr[i]  <= '0;
                r_used_addr[i]   <= '0;
            end
        end else begin
            r_dev_feat_select   <= n_dev_feat_select;
            r_drv_feat_select   <= n_drv_feat_select;
            r_accepted_features <= n_accepted_features;
            r_selected_queue    <= n_selected_queue;
            r_device_status     <= n_device_status;
            r_interrupt_bits    <= n_interrupt_bits;
            r_queue_size        <= n_queue_size;
            r_queue_ready       <= n_queue_ready;
            r_desc_addr         <= n_desc_addr;
            r_avail_addr        <= n_avail_addr;
            r_used_addr         <= n_used_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.unhandled_access, r_out.irq_pending, r_out.reset_event,
                         r_out.driver_ok_event, r_out.notify_queue, r_out.notify_valid,
                         r_out.read_data};

    `VMMIO_ASSERT_NOW(a_stall_holds_result, i_clk, i_rst_n, !o_s_tready, r_out_valid)
    `VMMIO_ASSERT_NOW(a_notify_clean, i_clk, i_rst_n, r_out_valid && r_out.notify_valid, r_out.read_data == 32'd0 && !r_out.unhandled_access)
    `VMMIO_ASSERT_NOW(a_driver_ok_status, i_clk, i_rst_n, r_out_valid && r_out.driver_ok_event, r_device_status[vmmio_pkg::STATUS_DRIVER_OK_BIT])
    `VMMIO_ASSERT_NOW(a_reset_clears, i_clk, i_rst_n, r_out_valid && r_out.reset_event, r_device_status == 32'd0 && r_interrupt_bits == 32'd0 && !r_out.irq_pending)
    `VMMIO_ASSERT_NEXT(a_raise_sets_irq, i_clk, i_rst_n, s_accept && i_s_tuser == vmmio_pkg::MODE_RAISE && in_data != 32'd0, r_interrupt_bits != 32'd0)

endmodule
